[hw/rtl/acs_pkg.sv]
// Package for the admittance control step: widths, register indexes, reset values,
// sequencer types and the fixed-point saturation helpers.
// No dependencies.
package acs_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int GAIN_W    = 31;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SHIFT_W   = PROD_W - FRAC_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURRENT_BIAS    = 3'd0,
      CSR_TORQUE_CONSTANT = 3'd1,
      CSR_GEAR_RATIO      = 3'd2,
      CSR_INVERSE_MASS    = 3'd3,
      CSR_DAMPING         = 3'd4,
      CSR_TIME_STEP       = 3'd5,
      CSR_PROP_GAIN       = 3'd6,
      CSR_DERIV_GAIN      = 3'd7
   } csr_index_type;

   localparam logic [DATA_W-1:0] RST_CURRENT_BIAS    = 32'sd0;
   localparam logic [DATA_W-1:0] RST_TORQUE_CONSTANT = 32'sd65536;
   localparam logic [DATA_W-1:0] RST_GEAR_RATIO      = 32'sd65536;
   localparam logic [GAIN_W-1:0] RST_INVERSE_MASS    = 31'd65536;
   localparam logic [GAIN_W-1:0] RST_DAMPING         = 31'd0;
   localparam logic [GAIN_W-1:0] RST_TIME_STEP       = 31'd66;
   localparam logic [DATA_W-1:0] RST_PROP_GAIN       = 32'sd327680;
   localparam logic [DATA_W-1:0] RST_DERIV_GAIN      = 32'sd32768;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      STEP_DIFF,
      STEP_TAU_A,
      STEP_TAU_B,
      STEP_DAMP,
      STEP_NET,
      STEP_ACCEL,
      STEP_DVEL,
      STEP_VEL,
      STEP_DPOS,
      STEP_POS,
      STEP_ERR,
      STEP_PTERM,
      STEP_DTERM,
      STEP_CMD
   } step_type;

   function automatic logic step_is_mul(input step_type step);
      logic is_mul;
      case (step)
         STEP_TAU_A, STEP_TAU_B, STEP_DAMP, STEP_ACCEL,
         STEP_DVEL, STEP_DPOS, STEP_PTERM, STEP_DTERM: begin
            is_mul = 1'b1;
         end
         default: begin
            is_mul = 1'b0;
         end
      endcase
      return is_mul;
   endfunction

   function automatic logic step_is_sub(input step_type step);
      return (step == STEP_DIFF) || (step == STEP_NET) || (step == STEP_ERR);
   endfunction

   function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] v);
      logic [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] shift_sat(input logic [PROD_W-1:0] p);
      logic [SHIFT_W-1:0]        q;
      logic [SHIFT_W-DATA_W:0]   hi;
      logic [DATA_W-1:0]         r;
      q  = p[PROD_W-1:FRAC_BITS];
      hi = q[SHIFT_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
         r = q[DATA_W-1:0];
      end else begin
         r = q[SHIFT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

[hw/rtl/admittance_control_step.sv]
// Top level of the admittance control step: one shared multiplier and adder under a sequencer.
// Depends on acs_pkg.
//
//   Channel   Ports                        Payload (lowest bits first)
//   input     req_tvalid/req_tready/tdata  motor_current, joint_position
//   output    rsp_tvalid/rsp_tready/tdata  torque_command, external_torque,
//                                          model_position, model_velocity
//   config    csr_wen/csr_index/csr_wdata  eight registers, write only
//
// One transaction runs six add steps and eight multiply steps through the single 32x32
// multiplier, where each multiply step registers its product before writing the result,
// then loads the result register; a new request waits until the last one has finished.
// The next request is taken as soon as the result is loaded, while it still waits for
// rsp_tready. A result that is still waiting holds the block in its last step until it
// leaves. Reset clears the model state and restores the register defaults.
module admittance_control_step (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // motor_current, joint_position
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // torque_command, external_torque, model_position,
                                     // model_velocity
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int DW = acs_pkg::DATA_W;
   localparam int GW = acs_pkg::GAIN_W;

   acs_pkg::state_type state_ff, state_in;
   acs_pkg::step_type  step_ff, step_in;
   logic               phase_ff, phase_in;

   logic [DW-1:0] bias_ff, tconst_ff, gear_ff, kp_ff, kd_ff;
   logic [GW-1:0] imass_ff, damp_ff, dt_ff;

   logic [DW-1:0] cur_ff, cur_in, jp_ff, jp_in;
   logic [DW-1:0] vel_ff, vel_in, pos_ff, pos_in;
   logic [DW-1:0] tau_ff, tau_in, work_ff, work_in, temp_ff, temp_in;
   logic [acs_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [127:0]  rsp_data_ff, rsp_data_in;

   logic signed [DW-1:0]              op_a, op_b;
   logic signed [acs_pkg::PROD_W-1:0] prod_full;
   logic signed [DW:0]                sum_full;
   logic [DW-1:0]                     result;
   logic                              rsp_free;

   assign req_tready = (state_ff == acs_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (step_ff)
         acs_pkg::STEP_DIFF:  begin op_a = cur_ff;               op_b = bias_ff;              end
         acs_pkg::STEP_TAU_A: begin op_a = work_ff;              op_b = tconst_ff;            end
         acs_pkg::STEP_TAU_B: begin op_a = work_ff;              op_b = gear_ff;              end
         acs_pkg::STEP_DAMP:  begin op_a = {1'b0, damp_ff};      op_b = vel_ff;               end
         acs_pkg::STEP_NET:   begin op_a = tau_ff;               op_b = work_ff;              end
         acs_pkg::STEP_ACCEL: begin op_a = work_ff;              op_b = {1'b0, imass_ff};     end
         acs_pkg::STEP_DVEL:  begin op_a = work_ff;              op_b = {1'b0, dt_ff};        end
         acs_pkg::STEP_VEL:   begin op_a = vel_ff;               op_b = work_ff;              end
         acs_pkg::STEP_DPOS:  begin op_a = vel_ff;               op_b = {1'b0, dt_ff};        end
         acs_pkg::STEP_POS:   begin op_a = pos_ff;               op_b = work_ff;              end
         acs_pkg::STEP_ERR:   begin op_a = pos_ff;               op_b = jp_ff;                end
         acs_pkg::STEP_PTERM: begin op_a = kp_ff;                op_b = work_ff;              end
         acs_pkg::STEP_DTERM: begin op_a = kd_ff;                op_b = vel_ff;               end
         acs_pkg::STEP_CMD:   begin op_a = work_ff;              op_b = temp_ff;              end
         default:             begin op_a = work_ff;              op_b = temp_ff;              end
      endcase
   end

   assign prod_full = op_a * op_b;
   assign sum_full  = acs_pkg::step_is_sub(step_ff) ? op_a - op_b : op_a + op_b;
   assign result    = acs_pkg::step_is_mul(step_ff) ? acs_pkg::shift_sat(prod_ff)
                                                    : acs_pkg::sat_sum(sum_full);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      jp_in        = jp_ff;
      vel_in       = vel_ff;
      pos_in       = pos_ff;
      tau_in       = tau_ff;
      work_in      = work_ff;
      temp_in      = temp_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         acs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cur_in   = req_tdata[DW-1:0];
               jp_in    = req_tdata[2*DW-1:DW];
               step_in  = acs_pkg::STEP_DIFF;
               phase_in = 1'b0;
               state_in = acs_pkg::ST_RUN;
            end
         end
         acs_pkg::ST_RUN: begin
            if (acs_pkg::step_is_mul(step_ff) && !phase_ff) begin
               prod_in  = prod_full;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               case (step_ff)
                  acs_pkg::STEP_TAU_B: tau_in  = result;
                  acs_pkg::STEP_VEL:   vel_in  = result;
                  acs_pkg::STEP_POS:   pos_in  = result;
                  acs_pkg::STEP_DTERM: temp_in = result;
                  default:             work_in = result;
               endcase
               if (step_ff == acs_pkg::STEP_CMD) begin
                  state_in = acs_pkg::ST_DONE;
               end else begin
                  step_in = acs_pkg::step_type'(step_ff + 4'd1);
               end
            end
         end
         acs_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {vel_ff, pos_ff, tau_ff, work_ff};
               state_in     = acs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = acs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acs_pkg::ST_IDLE;
         step_ff      <= acs_pkg::STEP_DIFF;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vel_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         vel_ff       <= vel_in;
         pos_ff       <= pos_in;
      end
      cur_ff      <= cur_in;
      jp_ff       <= jp_in;
      tau_ff      <= tau_in;
      work_ff     <= work_in;
      temp_ff     <= temp_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff   <= acs_pkg::RST_CURRENT_BIAS;
         tconst_ff <= acs_pkg::RST_TORQUE_CONSTANT;
         gear_ff   <= acs_pkg::RST_GEAR_RATIO;
         imass_ff  <= acs_pkg::RST_INVERSE_MASS;
         damp_ff   <= acs_pkg::RST_DAMPING;
         dt_ff     <= acs_pkg::RST_TIME_STEP;
         kp_ff     <= acs_pkg::RST_PROP_GAIN;
         kd_ff     <= acs_pkg::RST_DERIV_GAIN;
      end else if (csr_wen) begin
         case (acs_pkg::csr_index_type'(csr_index))
            acs_pkg::CSR_CURRENT_BIAS:    bias_ff   <= csr_wdata;
            acs_pkg::CSR_TORQUE_CONSTANT: tconst_ff <= csr_wdata;
            acs_pkg::CSR_GEAR_RATIO:      gear_ff   <= csr_wdata;
            acs_pkg::CSR_INVERSE_MASS:    imass_ff  <= csr_wdata[GW-1:0];
            acs_pkg::CSR_DAMPING:         damp_ff   <= csr_wdata[GW-1:0];
            acs_pkg::CSR_TIME_STEP:       dt_ff     <= csr_wdata[GW-1:0];
            acs_pkg::CSR_PROP_GAIN:       kp_ff     <= csr_wdata;
            acs_pkg::CSR_DERIV_GAIN:      kd_ff     <= csr_wdata;
            default:                      kd_ff     <= kd_ff;
         endcase
      end
   end

endmodule

[hw/rtl/acs_checker.sv]
// Port-level checker for the admittance control step, bound to the top level.
// Depends on admittance_control_step.
module acs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   // The block comes out of reset ready and with no result pending.
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // An accepted transaction keeps the input side busy; input ready does not return straight away.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("input ready too soon after a transaction");

   // A stalled result stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // A new result cannot appear in the cycle right after a transaction is accepted.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared without computation time");

endmodule

bind admittance_control_step acs_checker u_acs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
